// File: rtl/triangle_face_normal_unit_assert.svh
// assertion macros for the triangle face normal unit
// expects clk and rst_n in the scope of each use
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TFN_ASSERT_IMPLIES(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("triangle_face_normal_unit: check failed");
`define TFN_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("triangle_face_normal_unit: check failed");
`else
`define TFN_ASSERT_IMPLIES(label, cond, prop)
`define TFN_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// File: rtl/tfn_pkg.sv
// shared constants and types of the triangle face normal unit
// no dependencies
package tfn_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 16;

    localparam int SLOT_W  = 10;
    localparam int FIELD_W = 16;
    localparam int OUT_W   = 16;

    localparam int MAG_W      = 30;
    localparam int SUM_W      = 62;
    localparam int ISQ_W      = 64;
    localparam int ISQ_STEPS  = 32;
    localparam int ROOT_W     = 31;
    localparam int Q_W        = 15;
    localparam int NORM_SHIFT = 14;
    localparam int NUM_W      = 45;

    localparam logic [Q_W-1:0] NORM_ONE = 15'd16384;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [2:0] neg;
    } norm_tag_t;

endpackage

// File: rtl/tfn_in_if.sv
// request channel of the triangle face normal unit
// depends on tfn_pkg
interface tfn_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [tfn_pkg::SLOT_W-1:0]         vertex_slot;
    logic signed [tfn_pkg::FIELD_W-1:0] coord_x;
    logic signed [tfn_pkg::FIELD_W-1:0] coord_y;
    logic signed [tfn_pkg::FIELD_W-1:0] coord_z;
    logic [tfn_pkg::SLOT_W-1:0]         corner_a;
    logic [tfn_pkg::SLOT_W-1:0]         corner_b;
    logic [tfn_pkg::SLOT_W-1:0]         corner_c;

    modport source (
        output valid, command, vertex_slot, coord_x, coord_y, coord_z,
               corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, command, vertex_slot, coord_x, coord_y, coord_z,
               corner_a, corner_b, corner_c,
        output ready
    );
endinterface

// File: rtl/tfn_out_if.sv
// result channel of the triangle face normal unit
// depends on tfn_pkg
interface tfn_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tfn_pkg::OUT_W-1:0] normal_x;
    logic signed [tfn_pkg::OUT_W-1:0] normal_y;
    logic signed [tfn_pkg::OUT_W-1:0] normal_z;
    logic                             degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

// File: rtl/tfn_ram.sv
// generic single-port ram with registered read
// depends on tfn_pkg for default sizes
module tfn_ram #(
    parameter int WIDTH = 3 * tfn_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = tfn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: rtl/tfn_norm.sv
// normalizer: pipelined integer square root and three pipelined dividers
// depends on tfn_pkg
module tfn_norm (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  tfn_pkg::norm_tag_t               tag_in,
    input  logic [tfn_pkg::SUM_W-1:0]        sum_in,
    input  tfn_pkg::mag_t [2:0]              mag_in,
    output tfn_pkg::norm_tag_t               tag_out,
    output logic signed [tfn_pkg::OUT_W-1:0] normal_x,
    output logic signed [tfn_pkg::OUT_W-1:0] normal_y,
    output logic signed [tfn_pkg::OUT_W-1:0] normal_z
);

    tfn_pkg::norm_tag_t              sq_tag_reg  [tfn_pkg::ISQ_STEPS];
    logic [tfn_pkg::ISQ_W-1:0]       sq_rem_reg  [tfn_pkg::ISQ_STEPS];
    logic [tfn_pkg::ISQ_W-1:0]       sq_root_reg [tfn_pkg::ISQ_STEPS];
    tfn_pkg::mag_t [2:0]             sq_mag_reg  [tfn_pkg::ISQ_STEPS];

    tfn_pkg::norm_tag_t              dv_tag_reg [tfn_pkg::Q_W+1];
    logic [tfn_pkg::ROOT_W-1:0]      dv_den_reg [tfn_pkg::Q_W+1];
    logic [tfn_pkg::NUM_W-1:0]       dv_rem_reg [tfn_pkg::Q_W+1][3];
    logic [tfn_pkg::Q_W-1:0]         dv_quo_reg [tfn_pkg::Q_W+1][3];

    tfn_pkg::norm_tag_t              fin_tag_reg;
    logic signed [tfn_pkg::OUT_W-1:0] fin_reg [3];

    logic [tfn_pkg::ROOT_W-1:0]      root_fin;
    logic [tfn_pkg::Q_W-1:0]         q_clamp [3];

    // square root, one result bit per stage
    for (genvar k = 0; k < tfn_pkg::ISQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [tfn_pkg::ISQ_W-1:0] BitVal =
            tfn_pkg::ISQ_W'(1) << (tfn_pkg::ISQ_W - 2 - 2 * k);

        tfn_pkg::norm_tag_t        tag_prev;
        logic [tfn_pkg::ISQ_W-1:0] rem_prev;
        logic [tfn_pkg::ISQ_W-1:0] root_prev;
        logic [tfn_pkg::ISQ_W-1:0] trial;
        tfn_pkg::mag_t [2:0]       mag_prev;

        if (k == 0)
        begin : g_first
            assign tag_prev  = tag_in;
            assign rem_prev  = tfn_pkg::ISQ_W'(sum_in);
            assign root_prev = '0;
            assign mag_prev  = mag_in;
        end
        else
        begin : g_next
            assign tag_prev  = sq_tag_reg[k-1];
            assign rem_prev  = sq_rem_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign mag_prev  = sq_mag_reg[k-1];
        end

        assign trial = root_prev + BitVal;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_tag_reg[k] <= '0;
            end
            else if (en)
            begin
                sq_tag_reg[k] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_prev >= trial)
                begin
                    sq_rem_reg[k]  <= rem_prev - trial;
                    sq_root_reg[k] <= (root_prev >> 1) + BitVal;
                end
                else
                begin
                    sq_rem_reg[k]  <= rem_prev;
                    sq_root_reg[k] <= root_prev >> 1;
                end
                sq_mag_reg[k] <= mag_prev;
            end
        end
    end

    assign root_fin = sq_root_reg[tfn_pkg::ISQ_STEPS-1][tfn_pkg::ROOT_W-1:0];

    // divider setup: numerator with half the divisor for rounding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_tag_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_tag_reg[0] <= sq_tag_reg[tfn_pkg::ISQ_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_den_reg[0] <= root_fin;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <=
                    (tfn_pkg::NUM_W'(sq_mag_reg[tfn_pkg::ISQ_STEPS-1][i]) << tfn_pkg::NORM_SHIFT)
                    + tfn_pkg::NUM_W'(root_fin >> 1);
                dv_quo_reg[0][i] <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar j = 1; j <= tfn_pkg::Q_W; j++)
    begin : g_div
        localparam int QB = tfn_pkg::Q_W - j;

        logic [tfn_pkg::NUM_W-1:0] sub;

        assign sub = tfn_pkg::NUM_W'(dv_den_reg[j-1]) << QB;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_tag_reg[j] <= '0;
            end
            else if (en)
            begin
                dv_tag_reg[j] <= dv_tag_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[j] <= dv_den_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[j-1][i] >= sub)
                    begin
                        dv_rem_reg[j][i] <= dv_rem_reg[j-1][i] - sub;
                        dv_quo_reg[j][i] <= dv_quo_reg[j-1][i] | (tfn_pkg::Q_W'(1) << QB);
                    end
                    else
                    begin
                        dv_rem_reg[j][i] <= dv_rem_reg[j-1][i];
                        dv_quo_reg[j][i] <= dv_quo_reg[j-1][i];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_clamp[i] = (dv_quo_reg[tfn_pkg::Q_W][i] > tfn_pkg::NORM_ONE)
                       ? tfn_pkg::NORM_ONE : dv_quo_reg[tfn_pkg::Q_W][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_tag_reg <= '0;
        end
        else if (en)
        begin
            fin_tag_reg <= dv_tag_reg[tfn_pkg::Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_tag_reg[tfn_pkg::Q_W].degenerate)
                begin
                    fin_reg[i] <= '0;
                end
                else if (dv_tag_reg[tfn_pkg::Q_W].neg[i])
                begin
                    fin_reg[i] <= -$signed(tfn_pkg::OUT_W'(q_clamp[i]));
                end
                else
                begin
                    fin_reg[i] <= $signed(tfn_pkg::OUT_W'(q_clamp[i]));
                end
            end
        end
    end

    assign tag_out  = fin_tag_reg;
    assign normal_x = fin_reg[0];
    assign normal_y = fin_reg[1];
    assign normal_z = fin_reg[2];

endmodule

// File: rtl/triangle_face_normal_unit.sv
// top level of the triangle face normal unit: vertex store, cross product, normalize
// depends on tfn_pkg, tfn_in_if, tfn_out_if, tfn_ram, tfn_norm
//
// channel   side  handshake     payload
// request   in    valid/ready   command, vertex_slot, coord_x/y/z, corner_a/b/c
// result    out   valid/ready   normal_x/y/z, degenerate
//
// a load is a single ram write; a triangle reads its three corners one at a time on
// the single port of the vertex ram, and no new request is taken until its last read
// is issued and the front end is idle again
// reset clears control only; the vertex store holds nothing until written
// the whole pipeline holds while a result waits and another is about to land
`include "triangle_face_normal_unit_assert.svh"

module triangle_face_normal_unit #(
    parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEF,
    parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tfn_in_if.sink    request,
    tfn_out_if.source result
);

    localparam int AddrW  = $clog2(VERTEX_DEPTH);
    localparam int WordW  = 3 * COORD_WIDTH;
    localparam int EdgeW  = COORD_WIDTH + 1;
    localparam int ProdW  = 2 * EdgeW;
    localparam int CrossW = ProdW + 1;
    localparam int ShW    = $clog2(CrossW + 1);
    localparam int SqW    = 2 * tfn_pkg::MAG_W;

    typedef enum logic [2:0] {
        FE_IDLE   = 3'b001,
        FE_READ_B = 3'b010,
        FE_READ_C = 3'b100
    } fe_state_t;

    fe_state_t state_reg, state_next;
    logic [tfn_pkg::SLOT_W-1:0] corner_b_reg, corner_c_reg;

    logic advance, accept, last_valid;
    logic tri_accept, out_zero;

    logic             ram_en, ram_we;
    logic [AddrW-1:0] ram_addr;
    logic [WordW-1:0] ram_wdata, ram_rdata;

    logic      issue_valid, issue_zero;
    fe_state_t issue_phase;
    logic      rd_valid_reg, rd_zero_reg;
    fe_state_t rd_phase_reg;

    logic signed [COORD_WIDTH-1:0] rd_vert [3];
    logic signed [COORD_WIDTH-1:0] v0_reg [3];
    logic signed [COORD_WIDTH-1:0] v1_reg [3];

    logic                    e_valid_reg;
    logic signed [EdgeW-1:0] e1_reg [3];
    logic signed [EdgeW-1:0] e2_reg [3];

    logic                    p_valid_reg;
    logic signed [ProdW-1:0] p_reg [6];

    logic                     c_valid_reg;
    logic signed [CrossW-1:0] c_reg [3];

    tfn_pkg::norm_tag_t a_tag_reg;
    logic [CrossW-1:0]  a_mag_reg [3];

    tfn_pkg::norm_tag_t s_tag_reg;
    logic [ShW-1:0]     s_amt_reg;
    logic [CrossW-1:0]  s_mag_reg [3];
    logic [CrossW-1:0]  mag_or;
    logic [ShW-1:0]     amt;

    tfn_pkg::norm_tag_t  h_tag_reg;
    tfn_pkg::mag_t [2:0] h_mag_reg;

    tfn_pkg::norm_tag_t  q_tag_reg;
    tfn_pkg::mag_t [2:0] q_mag_reg;
    logic [SqW-1:0]      q_sq_reg [3];

    tfn_pkg::norm_tag_t          u_tag_reg;
    tfn_pkg::mag_t [2:0]         u_mag_reg;
    logic [tfn_pkg::SUM_W-1:0]   u_sum_reg;

    tfn_pkg::norm_tag_t               n_tag;
    logic signed [tfn_pkg::OUT_W-1:0] n_x, n_y, n_z;

    logic                             out_valid_reg;
    logic signed [tfn_pkg::OUT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                             out_degen_reg;

    assign last_valid    = n_tag.valid;
    assign advance       = !(last_valid && out_valid_reg && !result.ready);
    assign request.ready = advance && (state_reg == FE_IDLE);
    assign accept        = request.valid && request.ready;

    assign ram_wdata = {COORD_WIDTH'(request.coord_z), COORD_WIDTH'(request.coord_y),
                        COORD_WIDTH'(request.coord_x)};

    // front end: one ram access per cycle while the pipeline advances
    always_comb
    begin
        state_next  = state_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = AddrW'(request.vertex_slot);
        issue_valid = 1'b0;
        issue_phase = FE_IDLE;
        issue_zero  = 1'b0;
        unique case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == tfn_pkg::CMD_LOAD)
                    begin
                        ram_en = int'(request.vertex_slot) < VERTEX_DEPTH;
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        ram_en      = 1'b1;
                        ram_addr    = AddrW'(request.corner_a);
                        issue_valid = 1'b1;
                        issue_phase = FE_IDLE;
                        issue_zero  = !(int'(request.corner_a) < VERTEX_DEPTH);
                        state_next  = FE_READ_B;
                    end
                end
            end
            FE_READ_B:
            begin
                if (advance)
                begin
                    ram_en      = 1'b1;
                    ram_addr    = AddrW'(corner_b_reg);
                    issue_valid = 1'b1;
                    issue_phase = FE_READ_B;
                    issue_zero  = !(int'(corner_b_reg) < VERTEX_DEPTH);
                    state_next  = FE_READ_C;
                end
            end
            FE_READ_C:
            begin
                if (advance)
                begin
                    ram_en      = 1'b1;
                    ram_addr    = AddrW'(corner_c_reg);
                    issue_valid = 1'b1;
                    issue_phase = FE_READ_C;
                    issue_zero  = !(int'(corner_c_reg) < VERTEX_DEPTH);
                    state_next  = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_IDLE;
            rd_valid_reg <= 1'b0;
            rd_phase_reg <= FE_IDLE;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                rd_valid_reg <= issue_valid;
                rd_phase_reg <= issue_phase;
                rd_zero_reg  <= issue_zero;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && request.command == tfn_pkg::CMD_TRIANGLE)
        begin
            corner_b_reg <= request.corner_b;
            corner_c_reg <= request.corner_c;
        end
    end

    tfn_ram #(
        .WIDTH (WordW),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // out of range corners read as the origin
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rd_vert[k] = rd_zero_reg ? '0
                       : $signed(ram_rdata[k*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    // corner capture and edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            a_tag_reg   <= '0;
            s_tag_reg   <= '0;
            h_tag_reg   <= '0;
            q_tag_reg   <= '0;
            u_tag_reg   <= '0;
        end
        else if (advance)
        begin
            e_valid_reg <= rd_valid_reg && (rd_phase_reg == FE_READ_C);
            p_valid_reg <= e_valid_reg;
            c_valid_reg <= p_valid_reg;
            a_tag_reg.valid      <= c_valid_reg;
            a_tag_reg.degenerate <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
            a_tag_reg.neg        <= {c_reg[2][CrossW-1], c_reg[1][CrossW-1],
                                     c_reg[0][CrossW-1]};
            s_tag_reg <= a_tag_reg;
            h_tag_reg <= s_tag_reg;
            q_tag_reg <= h_tag_reg;
            u_tag_reg <= q_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rd_valid_reg)
        begin
            unique case (rd_phase_reg)
                FE_IDLE:
                begin
                    v0_reg <= rd_vert;
                end
                FE_READ_B:
                begin
                    v1_reg <= rd_vert;
                end
                FE_READ_C:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_reg[k] <= EdgeW'(v1_reg[k]) - EdgeW'(v0_reg[k]);
                        e2_reg[k] <= EdgeW'(rd_vert[k]) - EdgeW'(v0_reg[k]);
                    end
                end
                default:
                begin
                    v0_reg <= v0_reg;
                end
            endcase
        end
    end

    // cross product
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= CrossW'(p_reg[2*k]) - CrossW'(p_reg[2*k+1]);
            end
        end
    end

    // magnitudes and scale down to below 2^30
    always_comb
    begin
        mag_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        amt    = '0;
        for (int i = tfn_pkg::MAG_W; i < CrossW; i++)
        begin
            if (mag_or[i])
            begin
                amt = ShW'(i - tfn_pkg::MAG_W + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_mag_reg[k] <= c_reg[k][CrossW-1] ? CrossW'(-c_reg[k]) : CrossW'(c_reg[k]);
                s_mag_reg[k] <= a_mag_reg[k];
                h_mag_reg[k] <= tfn_pkg::MAG_W'(s_mag_reg[k] >> s_amt_reg);
                q_sq_reg[k]  <= SqW'(h_mag_reg[k]) * SqW'(h_mag_reg[k]);
            end
            s_amt_reg <= amt;
            q_mag_reg <= h_mag_reg;
            u_mag_reg <= q_mag_reg;
            u_sum_reg <= tfn_pkg::SUM_W'(q_sq_reg[0]) + tfn_pkg::SUM_W'(q_sq_reg[1])
                       + tfn_pkg::SUM_W'(q_sq_reg[2]);
        end
    end

    tfn_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .tag_in   (u_tag_reg),
        .sum_in   (u_sum_reg),
        .mag_in   (u_mag_reg),
        .tag_out  (n_tag),
        .normal_x (n_x),
        .normal_y (n_y),
        .normal_z (n_z)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_valid)
        begin
            out_x_reg     <= n_x;
            out_y_reg     <= n_y;
            out_z_reg     <= n_z;
            out_degen_reg <= n_tag.degenerate;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.normal_x   = out_x_reg;
    assign result.normal_y   = out_y_reg;
    assign result.normal_z   = out_z_reg;
    assign result.degenerate = out_degen_reg;

    assign tri_accept = accept && (request.command == tfn_pkg::CMD_TRIANGLE);
    assign out_zero   = (result.normal_x == '0) && (result.normal_y == '0)
                     && (result.normal_z == '0);

    `TFN_ASSERT_NEXT(a_triangle_starts_reads, tri_accept, state_reg == FE_READ_B)
    `TFN_ASSERT_IMPLIES(a_degenerate_is_zero, result.valid && result.degenerate, out_zero)
    `TFN_ASSERT_IMPLIES(a_normal_not_zero, result.valid && !result.degenerate, !out_zero)

endmodule
